>>> hdl/bhpq_pkg.sv
// shared constants and helper functions for the binary heap priority queue
package bhpq_pkg;

	localparam int SLOT_BITS  = 17;
	localparam int LEVEL_BITS = 5;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// entries held by one tree level, the last level may be partial
	function automatic int lvl_depth(int cap, int lvl);
		int lo;
		int span;
		lo   = 1 << lvl;
		span = cap + 1 - lo;
		return (span < lo) ? span : lo;
	endfunction

	// tree level of a one-based slot number
	function automatic logic [LEVEL_BITS-1:0] slot_level(logic [SLOT_BITS-1:0] s);
		logic [LEVEL_BITS-1:0] l;
		l = '0;
		for (int b = 0; b < SLOT_BITS; b++) begin
			if (s[b]) l = LEVEL_BITS'(b);
		end
		return l;
	endfunction

	function automatic logic key_better(logic [63:0] a, logic [63:0] b, logic largest);
		return largest ? (a > b) : (a < b);
	endfunction

endpackage

>>> hdl/bhpq_cell.sv
// one heap level: entry store for the level plus the sift step logic
module bhpq_cell import bhpq_pkg::*; #(
	parameter int LEVEL = 0,
	parameter int DEPTH = 1,
	parameter int KW    = 32,
	parameter int PW    = 32,
	parameter int XW    = 1,
	parameter int CW    = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                largest_first,
	input  logic [CW-1:0]       count,
	input  logic                dn_in_vld,
	input  logic [KW+PW-1:0]    dn_in_ent,
	input  logic [XW-1:0]       dn_in_idx,
	output logic                dn_out_vld,
	output logic [KW+PW-1:0]    dn_out_ent,
	output logic [XW-1:0]       dn_out_idx,
	input  logic                up_in_vld,
	input  logic [KW+PW-1:0]    up_in_ent,
	input  logic [XW-1:0]       up_in_idx,
	output logic                up_out_vld,
	output logic [KW+PW-1:0]    up_out_ent,
	output logic [XW-1:0]       up_out_idx,
	input  logic                rd_en,
	input  logic [XW-1:0]       rd_a0,
	input  logic [XW-1:0]       rd_a1,
	output logic [KW+PW-1:0]    rd_d0,
	output logic [KW+PW-1:0]    rd_d1,
	output logic                ch_en,
	output logic [XW-1:0]       ch_a0,
	output logic [XW-1:0]       ch_a1,
	input  logic [KW+PW-1:0]    ch_d0,
	input  logic [KW+PW-1:0]    ch_d1,
	output logic                par_en,
	output logic [XW-1:0]       par_a,
	input  logic [KW+PW-1:0]    par_d,
	output logic                done,
	output logic [KW+PW-1:0]    head
);

	localparam int EW = KW + PW;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW = CW + 1;

	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_DOWN = 2'd1;
	localparam logic [1:0] C_UP   = 2'd2;

	logic [1:0]    state_q;
	logic [1:0]    state_d;
	logic [EW-1:0] x_q;
	logic [XW-1:0] idx_q;
	logic          dn_vld_q;
	logic          up_vld_q;
	logic [EW-1:0] dn_ent_q;
	logic [EW-1:0] up_ent_q;
	logic [XW-1:0] dn_idx_q;
	logic [XW-1:0] up_idx_q;
	logic [EW-1:0] rd0_q;
	logic [EW-1:0] rd1_q;
	logic [SW-1:0] left_in;
	logic [SW-1:0] left_q;
	logic          has_child;
	logic          right_ok;
	logic          pick_right;
	logic          stop_dn;
	logic          rise_up;
	logic [EW-1:0] child;
	logic          we;
	logic [XW-1:0] wa;
	logic [EW-1:0] wd;
	logic          send_dn;
	logic          send_up;

	function automatic logic [63:0] key_of(logic [EW-1:0] e);
		return 64'(e[EW-1:PW]);
	endfunction

	// slot numbers of the left child, for the incoming and the held entry
	assign left_in   = (SW'(1) << (LEVEL + 1)) + (SW'(dn_in_idx) << 1);
	assign left_q    = (SW'(1) << (LEVEL + 1)) + (SW'(idx_q) << 1);
	assign has_child = (left_in <= SW'(count));
	assign right_ok  = (left_q < SW'(count));

	assign pick_right = right_ok && key_better(key_of(ch_d1), key_of(ch_d0), largest_first);
	assign child      = pick_right ? ch_d1 : ch_d0;
	assign stop_dn    = key_better(key_of(x_q), key_of(child), largest_first);
	assign rise_up    = key_better(key_of(x_q), key_of(par_d), largest_first);

	assign ch_en  = (state_q == C_IDLE) && dn_in_vld && has_child;
	assign ch_a0  = XW'({dn_in_idx, 1'b0});
	assign ch_a1  = XW'({dn_in_idx, 1'b1});
	assign par_en = (LEVEL != 0) && (state_q == C_IDLE) && !dn_in_vld && up_in_vld;
	assign par_a  = up_in_idx >> 1;

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		wa      = idx_q;
		wd      = x_q;
		done    = 1'b0;
		send_dn = 1'b0;
		send_up = 1'b0;
		case (state_q)
			C_IDLE: begin
				if (dn_in_vld) begin
					if (has_child) begin
						state_d = C_DOWN;
					end else begin
						we   = 1'b1;
						wa   = dn_in_idx;
						wd   = dn_in_ent;
						done = 1'b1;
					end
				end else if (up_in_vld) begin
					if (LEVEL != 0) begin
						state_d = C_UP;
					end else begin
						we   = 1'b1;
						wa   = up_in_idx;
						wd   = up_in_ent;
						done = 1'b1;
					end
				end
			end
			C_DOWN: begin
				state_d = C_IDLE;
				we      = 1'b1;
				if (stop_dn) begin
					done = 1'b1;
				end else begin
					wd      = child;
					send_dn = 1'b1;
				end
			end
			C_UP: begin
				state_d = C_IDLE;
				we      = 1'b1;
				if (rise_up) begin
					wd      = par_d;
					send_up = 1'b1;
				end else begin
					done = 1'b1;
				end
			end
			default: begin
				state_d = C_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= C_IDLE;
			dn_vld_q <= 1'b0;
			up_vld_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			dn_vld_q <= send_dn;
			up_vld_q <= send_up;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE) begin
			if (dn_in_vld) begin
				x_q   <= dn_in_ent;
				idx_q <= dn_in_idx;
			end else if (up_in_vld) begin
				x_q   <= up_in_ent;
				idx_q <= up_in_idx;
			end
		end
		if (send_dn) begin
			dn_ent_q <= x_q;
			dn_idx_q <= pick_right ? XW'({idx_q, 1'b1}) : XW'({idx_q, 1'b0});
		end
		if (send_up) begin
			up_ent_q <= x_q;
			up_idx_q <= idx_q >> 1;
		end
	end

	if (DEPTH == 1) begin : g_one
		logic [EW-1:0] mem_q;

		always_ff @(posedge clk) begin
			if (we) begin
				mem_q <= wd;
			end
			if (rd_en) begin
				rd0_q <= mem_q;
				rd1_q <= mem_q;
			end
		end

		assign head = mem_q;
	end else begin : g_ram
		logic [EW-1:0] mem_q [DEPTH];

		always_ff @(posedge clk) begin
			if (we) begin
				mem_q[wa[AW-1:0]] <= wd;
			end
			if (rd_en) begin
				rd0_q <= mem_q[rd_a0[AW-1:0]];
				rd1_q <= mem_q[rd_a1[AW-1:0]];
			end
		end

		assign head = '0;
	end

	assign rd_d0      = rd0_q;
	assign rd_d1      = rd1_q;
	assign dn_out_vld = dn_vld_q;
	assign dn_out_ent = dn_ent_q;
	assign dn_out_idx = dn_idx_q;
	assign up_out_vld = up_vld_q;
	assign up_out_ent = up_ent_q;
	assign up_out_idx = up_idx_q;

endmodule

>>> hdl/binary_heap_priority_queue.sv
// binary heap priority queue built as a chain of per-level cells
// an insert writes the entry at its level and sifts it up toward the root, a remove reads the last
// entry, loads it at the root and sifts it down; refused requests and removal of the last entry go
// straight to the result state
// one item at a time: the next transfer is taken the cycle after the result is registered
// reset clears the count and the direction, the entry store is not cleared
module binary_heap_priority_queue import bhpq_pkg::*; #(
	parameter int CAPACITY      = 256,
	parameter int KEY_WIDTH     = 32,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic                            cfg_wr_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            req_type,
	input  logic [KEY_WIDTH-1:0]            entry_key,
	input  logic [PAYLOAD_WIDTH-1:0]        entry_payload,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [KEY_WIDTH-1:0]            best_key,
	output logic [PAYLOAD_WIDTH-1:0]        best_payload,
	output logic [$clog2(CAPACITY+1)-1:0]   entry_count,
	output logic                            queue_empty,
	output logic [1:0]                      op_status
);

	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int NLEV = CW;
	localparam int XW   = NLEV - 1;
	localparam int LVW  = $clog2(NLEV);
	localparam int SW   = CW + 1;
	localparam int EW   = KEY_WIDTH + PAYLOAD_WIDTH;

	localparam logic [2:0] T_IDLE = 3'd0;
	localparam logic [2:0] T_INJ  = 3'd1;
	localparam logic [2:0] T_RD   = 3'd2;
	localparam logic [2:0] T_LD   = 3'd3;
	localparam logic [2:0] T_SIFT = 3'd4;
	localparam logic [2:0] T_RES  = 3'd5;

	logic [2:0]               state_q;
	logic [CW-1:0]            count_q;
	logic                     order_q;
	logic [LVW-1:0]           lvl_q;
	logic [XW-1:0]            idx_q;
	logic [EW-1:0]            ent_q;
	logic [1:0]               status_q;
	logic                     out_vld_q;
	logic [KEY_WIDTH-1:0]     best_key_q;
	logic [PAYLOAD_WIDTH-1:0] best_payload_q;
	logic [CW-1:0]            entry_count_q;
	logic                     queue_empty_q;
	logic [1:0]               op_status_q;

	logic                     take;
	logic                     out_free;
	logic                     full;
	logic [SW-1:0]            slot_c;
	logic [LVW-1:0]           lvl_c;
	logic [XW-1:0]            idx_c;
	logic                     inj_up;
	logic                     inj_dn;
	logic                     top_rd;
	logic                     done_any;
	logic [EW-1:0]            last_ent;
	logic [EW-1:0]            root;

	logic [NLEV-1:0]          ch_en_w;
	logic [NLEV-1:0]          par_en_w;
	logic [NLEV-1:0]          dn_vld_w;
	logic [NLEV-1:0]          up_vld_w;
	logic [NLEV-1:0]          rd_en_w;
	logic [NLEV-1:0]          done_w;
	logic [XW-1:0]            ch_a0_w  [NLEV];
	logic [XW-1:0]            ch_a1_w  [NLEV];
	logic [XW-1:0]            par_a_w  [NLEV];
	logic [XW-1:0]            dn_idx_w [NLEV];
	logic [XW-1:0]            up_idx_w [NLEV];
	logic [XW-1:0]            rd_a0_w  [NLEV];
	logic [XW-1:0]            rd_a1_w  [NLEV];
	logic [EW-1:0]            dn_ent_w [NLEV];
	logic [EW-1:0]            up_ent_w [NLEV];
	logic [EW-1:0]            rd_d0_w  [NLEV];
	logic [EW-1:0]            rd_d1_w  [NLEV];
	logic [EW-1:0]            head_w   [NLEV];

	assign in_ready = (state_q == T_IDLE);
	assign take     = in_valid && in_ready;
	assign out_free = !out_vld_q || out_ready;
	assign full     = (count_q == CW'(CAPACITY));

	// slot of the new last entry for an insert, of the current last for a remove
	assign slot_c = (req_type == REQ_INSERT) ? (SW'(count_q) + SW'(1)) : SW'(count_q);
	assign lvl_c  = LVW'(slot_level(SLOT_BITS'(slot_c)));
	assign idx_c  = XW'(slot_c ^ (SW'(1) << lvl_c));

	assign inj_up   = (state_q == T_INJ);
	assign top_rd   = (state_q == T_RD);
	assign inj_dn   = (state_q == T_LD);
	assign done_any = |done_w;
	assign last_ent = rd_d0_w[lvl_q];
	assign root     = head_w[0];

	for (genvar g = 0; g < NLEV; g++) begin : g_lvl
		localparam int DEP = lvl_depth(CAPACITY, g);

		logic          sel;
		logic          ab_ch_en;
		logic [XW-1:0] ab_ch_a0;
		logic [XW-1:0] ab_ch_a1;
		logic          ab_dn_vld;
		logic [EW-1:0] ab_dn_ent;
		logic [XW-1:0] ab_dn_idx;
		logic [EW-1:0] ab_par_d;
		logic          bl_par_en;
		logic [XW-1:0] bl_par_a;
		logic          bl_up_vld;
		logic [EW-1:0] bl_up_ent;
		logic [XW-1:0] bl_up_idx;
		logic [EW-1:0] bl_ch_d0;
		logic [EW-1:0] bl_ch_d1;
		logic          up_vld_in;
		logic [EW-1:0] up_ent_in;
		logic [XW-1:0] up_idx_in;

		assign sel = (lvl_q == LVW'(g));

		if (g == 0) begin : g_root
			assign ab_ch_en  = 1'b0;
			assign ab_ch_a0  = '0;
			assign ab_ch_a1  = '0;
			assign ab_dn_vld = inj_dn;
			assign ab_dn_ent = last_ent;
			assign ab_dn_idx = '0;
			assign ab_par_d  = '0;
		end else begin : g_inner
			assign ab_ch_en  = ch_en_w[g-1];
			assign ab_ch_a0  = ch_a0_w[g-1];
			assign ab_ch_a1  = ch_a1_w[g-1];
			assign ab_dn_vld = dn_vld_w[g-1];
			assign ab_dn_ent = dn_ent_w[g-1];
			assign ab_dn_idx = dn_idx_w[g-1];
			assign ab_par_d  = rd_d0_w[g-1];
		end

		if (g == NLEV - 1) begin : g_leaf
			assign bl_par_en = 1'b0;
			assign bl_par_a  = '0;
			assign bl_up_vld = 1'b0;
			assign bl_up_ent = '0;
			assign bl_up_idx = '0;
			assign bl_ch_d0  = '0;
			assign bl_ch_d1  = '0;
		end else begin : g_branch
			assign bl_par_en = par_en_w[g+1];
			assign bl_par_a  = par_a_w[g+1];
			assign bl_up_vld = up_vld_w[g+1];
			assign bl_up_ent = up_ent_w[g+1];
			assign bl_up_idx = up_idx_w[g+1];
			assign bl_ch_d0  = rd_d0_w[g+1];
			assign bl_ch_d1  = rd_d1_w[g+1];
		end

		// only one requester is active at a time
		assign rd_en_w[g] = ab_ch_en | bl_par_en | (top_rd & sel);
		assign rd_a0_w[g] = (ab_ch_en ? ab_ch_a0 : '0) | (bl_par_en ? bl_par_a : '0)
			| ((top_rd & sel) ? idx_q : '0);
		assign rd_a1_w[g] = ab_ch_en ? ab_ch_a1 : '0;

		assign up_vld_in = bl_up_vld | (inj_up & sel);
		assign up_ent_in = (bl_up_vld ? bl_up_ent : '0) | ((inj_up & sel) ? ent_q : '0);
		assign up_idx_in = (bl_up_vld ? bl_up_idx : '0) | ((inj_up & sel) ? idx_q : '0);

		bhpq_cell #(
			.LEVEL (g),
			.DEPTH (DEP),
			.KW    (KEY_WIDTH),
			.PW    (PAYLOAD_WIDTH),
			.XW    (XW),
			.CW    (CW)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.largest_first (order_q),
			.count         (count_q),
			.dn_in_vld     (ab_dn_vld),
			.dn_in_ent     (ab_dn_ent),
			.dn_in_idx     (ab_dn_idx),
			.dn_out_vld    (dn_vld_w[g]),
			.dn_out_ent    (dn_ent_w[g]),
			.dn_out_idx    (dn_idx_w[g]),
			.up_in_vld     (up_vld_in),
			.up_in_ent     (up_ent_in),
			.up_in_idx     (up_idx_in),
			.up_out_vld    (up_vld_w[g]),
			.up_out_ent    (up_ent_w[g]),
			.up_out_idx    (up_idx_w[g]),
			.rd_en         (rd_en_w[g]),
			.rd_a0         (rd_a0_w[g]),
			.rd_a1         (rd_a1_w[g]),
			.rd_d0         (rd_d0_w[g]),
			.rd_d1         (rd_d1_w[g]),
			.ch_en         (ch_en_w[g]),
			.ch_a0         (ch_a0_w[g]),
			.ch_a1         (ch_a1_w[g]),
			.ch_d0         (bl_ch_d0),
			.ch_d1         (bl_ch_d1),
			.par_en        (par_en_w[g]),
			.par_a         (par_a_w[g]),
			.par_d         (ab_par_d),
			.done          (done_w[g]),
			.head          (head_w[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= T_IDLE;
			count_q   <= '0;
			order_q   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				order_q <= cfg_wr_data;
			end
			if (state_q == T_RES && out_free) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				T_IDLE: begin
					if (take) begin
						if (req_type == REQ_INSERT) begin
							if (full) begin
								state_q <= T_RES;
							end else begin
								count_q <= count_q + CW'(1);
								state_q <= T_INJ;
							end
						end else if (count_q == '0) begin
							state_q <= T_RES;
						end else begin
							count_q <= count_q - CW'(1);
							state_q <= (count_q == CW'(1)) ? T_RES : T_RD;
						end
					end
				end
				T_INJ, T_LD: begin
					state_q <= done_any ? T_RES : T_SIFT;
				end
				T_RD: begin
					state_q <= T_LD;
				end
				T_SIFT: begin
					if (done_any) state_q <= T_RES;
				end
				T_RES: begin
					if (out_free) begin
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ent_q <= {entry_key, entry_payload};
			lvl_q <= lvl_c;
			idx_q <= idx_c;
			if (req_type == REQ_INSERT) begin
				status_q <= full ? ST_FULL : ST_OK;
			end else begin
				status_q <= (count_q == '0) ? ST_EMPTY : ST_OK;
			end
		end
		if (state_q == T_RES && out_free) begin
			best_key_q     <= (count_q != '0) ? root[EW-1:PAYLOAD_WIDTH] : '0;
			best_payload_q <= (count_q != '0) ? root[PAYLOAD_WIDTH-1:0] : '0;
			entry_count_q  <= count_q;
			queue_empty_q  <= (count_q == '0);
			op_status_q    <= status_q;
		end
	end

	assign out_valid    = out_vld_q;
	assign best_key     = best_key_q;
	assign best_payload = best_payload_q;
	assign entry_count  = entry_count_q;
	assign queue_empty  = queue_empty_q;
	assign op_status    = op_status_q;

endmodule

>>> tb/bhpq_result_checker.sv
// transfer monitor, heap predictor and result comparison for the priority queue
`timescale 1ns / 100ps

module bhpq_result_checker import bhpq_pkg::*; #(
	parameter int CAPACITY = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        req_type,
	input  logic [31:0] entry_key,
	input  logic [31:0] entry_payload,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [31:0] best_key,
	input  logic [31:0] best_payload,
	input  logic [8:0]  entry_count,
	input  logic        queue_empty,
	input  logic [1:0]  op_status,
	output int          outstanding,
	output int          mismatch_count
);

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] payload;
		logic [8:0]  count;
		logic        empty;
		logic [1:0]  status;
	} root_view_t;

	logic [31:0] slot_key     [1:CAPACITY];
	logic [31:0] slot_payload [1:CAPACITY];
	int          fill_level;
	logic        largest_first;
	root_view_t  expected_views [$];
	root_view_t  predicted;
	root_view_t  oldest;

	function automatic logic serves_before(logic [31:0] a, logic [31:0] b, logic largest);
		return largest ? (a > b) : (a < b);
	endfunction

	task automatic swap_slots(input int a, input int b);
		logic [31:0] k;
		logic [31:0] p;
		k               = slot_key[a];
		p               = slot_payload[a];
		slot_key[a]     = slot_key[b];
		slot_payload[a] = slot_payload[b];
		slot_key[b]     = k;
		slot_payload[b] = p;
	endtask

	task automatic apply_request(input logic kind, input logic [31:0] k, input logic [31:0] p,
			output root_view_t v);
		int         pos;
		int         child;
		logic       settled;
		logic [1:0] st;
		st = ST_OK;
		if (kind == REQ_INSERT) begin
			if (fill_level >= CAPACITY) begin
				st = ST_FULL;
			end else begin
				fill_level++;
				slot_key[fill_level]     = k;
				slot_payload[fill_level] = p;
				pos = fill_level;
				while (pos > 1 && serves_before(slot_key[pos], slot_key[pos / 2], largest_first)) begin
					swap_slots(pos, pos / 2);
					pos = pos / 2;
				end
			end
		end else begin
			if (fill_level == 0) begin
				st = ST_EMPTY;
			end else begin
				swap_slots(1, fill_level);
				fill_level--;
				pos     = 1;
				settled = 1'b0;
				while (!settled && pos * 2 <= fill_level) begin
					child = pos * 2;
					if (child < fill_level &&
							serves_before(slot_key[child + 1], slot_key[child], largest_first))
						child++;
					if (serves_before(slot_key[pos], slot_key[child], largest_first)) begin
						settled = 1'b1;
					end else begin
						swap_slots(pos, child);
						pos = child;
					end
				end
			end
		end
		v.key     = (fill_level > 0) ? slot_key[1] : 32'h0;
		v.payload = (fill_level > 0) ? slot_payload[1] : 32'h0;
		v.count   = 9'(fill_level);
		v.empty   = (fill_level == 0);
		v.status  = st;
	endtask

	task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, actual %0h", name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_level     = 0;
			largest_first  = 1'b0;
			mismatch_count = 0;
			expected_views.delete();
			outstanding   <= 0;
		end else begin
			if (cfg_wr_en)
				largest_first = cfg_wr_data;
			if (in_valid && in_ready) begin
				apply_request(req_type, entry_key, entry_payload, predicted);
				expected_views.push_back(predicted);
			end
			if (out_valid && out_ready) begin
				if (expected_views.size() == 0) begin
					$error("result transfer with no request pending");
					mismatch_count++;
				end else begin
					oldest = expected_views.pop_front();
					check_field("best_key", oldest.key, best_key);
					check_field("best_payload", oldest.payload, best_payload);
					check_field("entry_count", 32'(oldest.count), 32'(entry_count));
					check_field("queue_empty", 32'(oldest.empty), 32'(queue_empty));
					check_field("op_status", 32'(oldest.status), 32'(op_status));
				end
			end
			outstanding <= expected_views.size();
		end
	end

endmodule

>>> tb/binary_heap_priority_queue_test.sv
// top of the priority queue regression: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps

module binary_heap_priority_queue_test import bhpq_pkg::*;;

	localparam int CAPACITY      = 256;
	localparam int LONG_HOLD     = 300;
	localparam int SETTLE_CYCLES = 32;
	localparam int STALL_LIMIT   = 2000;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        cfg_wr_en     = 1'b0;
	logic        cfg_wr_data   = 1'b0;
	logic        in_valid      = 1'b0;
	logic        in_ready;
	logic        req_type      = REQ_INSERT;
	logic [31:0] entry_key     = 32'h0;
	logic [31:0] entry_payload = 32'h0;
	logic        out_valid;
	logic        out_ready     = 1'b0;
	logic [31:0] best_key;
	logic [31:0] best_payload;
	logic [8:0]  entry_count;
	logic        queue_empty;
	logic [1:0]  op_status;

	int          outstanding;
	int          mismatch_count;
	int          quiet_cycles  = 0;
	bit          idling_on     = 1'b1;
	bit          rx_hold_request = 1'b0;
	bit          rx_hold_done    = 1'b0;

	binary_heap_priority_queue #(
		.CAPACITY(CAPACITY),
		.KEY_WIDTH(32),
		.PAYLOAD_WIDTH(32)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.entry_key(entry_key),
		.entry_payload(entry_payload),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.best_key(best_key),
		.best_payload(best_payload),
		.entry_count(entry_count),
		.queue_empty(queue_empty),
		.op_status(op_status)
	);

	bhpq_result_checker #(.CAPACITY(CAPACITY)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.entry_key(entry_key),
		.entry_payload(entry_payload),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.best_key(best_key),
		.best_payload(best_payload),
		.entry_count(entry_count),
		.queue_empty(queue_empty),
		.op_status(op_status),
		.outstanding(outstanding),
		.mismatch_count(mismatch_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// result side: short random stalls, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (rx_hold_request && !rx_hold_done) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				rx_hold_done = 1'b1;
				out_ready <= 1'b1;
			end else if (idling_on && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("binary_heap_priority_queue regression: fail");
			$finish;
		end
	end

	function automatic logic [31:0] random_key();
		case ($urandom_range(0, 3))
			0:       return 32'($urandom_range(0, 7));
			1:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
			default: return $urandom();
		endcase
	endfunction

	task automatic send_request(input logic kind, input logic [31:0] k, input logic [31:0] p);
		in_valid      <= 1'b1;
		req_type      <= kind;
		entry_key     <= k;
		entry_payload <= p;
		do @(posedge clk); while (!in_ready);
		if (idling_on && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_direction(input logic largest);
		wait_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= largest;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
	endtask

	task automatic run_mixed(input int n);
		int pct;
		for (int i = 0; i < n; i++) begin
			pct = (i < n / 2) ? 70 : 35;
			if ($urandom_range(0, 99) < pct)
				send_request(REQ_INSERT, random_key(), $urandom());
			else
				send_request(REQ_REMOVE, $urandom(), $urandom());
		end
	endtask

	task automatic run_fill_and_drain();
		repeat (CAPACITY + 4) send_request(REQ_INSERT, random_key(), $urandom());
		repeat (CAPACITY + 3) send_request(REQ_REMOVE, $urandom(), $urandom());
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// smallest first out of reset: empty remove, extremes, ties
		send_request(REQ_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(REQ_INSERT, 32'h5, 32'h1234_5678);
		send_request(REQ_INSERT, 32'h0, 32'h0);
		send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(REQ_INSERT, 32'h5, 32'hA5A5_5A5A);
		send_request(REQ_INSERT, 32'h0, 32'hFFFF_FFFF);
		send_request(REQ_INSERT, 32'h3, 32'h0000_0003);
		send_request(REQ_REMOVE, 32'h0, 32'h0);
		send_request(REQ_REMOVE, 32'h0, 32'h0);

		// flip direction with entries still stored
		set_direction(1'b1);
		send_request(REQ_INSERT, 32'hFFFF_FFFE, 32'h5A5A_A5A5);
		send_request(REQ_INSERT, 32'h1, 32'h0000_0001);
		send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h8000_0000);
		repeat (7) send_request(REQ_REMOVE, 32'h0, 32'h0);
		send_request(REQ_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		run_mixed(150);

		set_direction(1'b0);
		run_fill_and_drain();

		set_direction(1'b1);
		rx_hold_request = 1'b1;
		run_mixed(150);

		set_direction(1'b0);
		run_mixed(130);

		set_direction(1'b1);
		idling_on = 1'b0;
		run_mixed(130);

		wait_idle();
		if (mismatch_count == 0)
			$display("binary_heap_priority_queue regression: pass");
		else
			$display("binary_heap_priority_queue regression: fail");
		$finish;
	end

endmodule

>>> filelist.f
hdl/bhpq_pkg.sv
hdl/bhpq_cell.sv
hdl/binary_heap_priority_queue.sv
tb/bhpq_result_checker.sv
tb/binary_heap_priority_queue_test.sv
